### rtl/core/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg - shared definitions of the positional record table
// record layout, command and status codes, sequencer states and defaults
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

  // default table depth
  localparam int TABLE_SLOTS_DEF = 64;

  // fixed field widths
  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int CODE_W   = 64;
  localparam int NAME_W   = 64;
  localparam int PRICE_W  = 32;
  localparam int STOCK_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR      = 3'd0,
    KIND_APPEND     = 3'd1,
    KIND_INSERT     = 3'd2,
    KIND_DELETE     = 3'd3,
    KIND_FIND_NAME  = 3'd4,
    KIND_FIND_PRICE = 3'd5,
    KIND_FIND_STOCK = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0]         code;
    logic [NAME_W-1:0]         name;
    logic [PRICE_W-1:0]        price;
    logic signed [STOCK_W-1:0] stock;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_INS_PUT,
    S_DEL_CAP,
    S_DN_RD,
    S_DN_WR,
    S_DEL_END,
    S_SC_RD,
    S_SC_CHK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

### rtl/core/prt_if.sv
// ----------------------------------------------------------------------------
// prt_cmd_if / prt_res_if - command and result channels
// valid/ready channels carrying one command or one result per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface prt_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [prt_pkg::KIND_W-1:0]          kind;
  logic [prt_pkg::POS_W-1:0]           position;
  logic [prt_pkg::CODE_W-1:0]          item_code;
  logic [prt_pkg::NAME_W-1:0]          item_name;
  logic [prt_pkg::PRICE_W-1:0]         unit_price;
  logic signed [prt_pkg::STOCK_W-1:0]  stock_level;

  modport source (
    output valid, kind, position, item_code, item_name, unit_price, stock_level,
    input  ready
  );
  modport sink (
    input  valid, kind, position, item_code, item_name, unit_price, stock_level,
    output ready
  );
endinterface

interface prt_res_if;
  logic                                valid;
  logic                                ready;
  logic [prt_pkg::STATUS_W-1:0]        status;
  logic [prt_pkg::POS_W-1:0]           hit_position;
  logic [prt_pkg::CODE_W-1:0]          out_code;
  logic [prt_pkg::NAME_W-1:0]          out_name;
  logic [prt_pkg::PRICE_W-1:0]         out_price;
  logic signed [prt_pkg::STOCK_W-1:0]  out_stock;
  logic [prt_pkg::POS_W-1:0]           entry_total;

  modport source (
    output valid, status, hit_position, out_code, out_name, out_price, out_stock,
           entry_total,
    input  ready
  );
  modport sink (
    input  valid, status, hit_position, out_code, out_name, out_price, out_stock,
           entry_total,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/positional_record_table_unit.sv
// ----------------------------------------------------------------------------
// positional_record_table_unit - ordered 1-based record table
// clear, append, insert, delete and first-match search under a sequencer
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer carries
//  --------+-----------+----------------------------------------------------
//  cmd     | in        | kind, position, item_code, item_name, unit_price,
//          |           | stock_level
//  res     | out       | status, hit_position, out_code, out_name, out_price,
//          |           | out_stock, entry_total
//
//  steps: clear, append, failed commands and unknown kind go from idle to
//  the result state; insert shifts slots up from the tail, delete keeps the
//  victim and shifts slots down, a search scans from the first slot; each
//  shifted or scanned slot takes a read step and a write/compare step
//  reset: synchronous, clears the count and the sequencer; no clearing pass
//  stalls: cmd.ready is high only while idle; a finished result waits in the
//  output register, and the next result waits until that one is taken
// ----------------------------------------------------------------------------
`default_nettype none

module positional_record_table_unit #(
  parameter int TABLE_SLOTS = prt_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  prt_cmd_if.sink    cmd,
  prt_res_if.source  res
);

  // address, count and a compare width wide enough for both count and position
  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int PW = (CW > prt_pkg::POS_W) ? CW : prt_pkg::POS_W;

  // sequencer and working registers
  prt_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    idx, idx_next;
  prt_pkg::kind_t   cur_kind, cur_kind_next;
  logic [PW-1:0]    cur_pos, cur_pos_next;
  prt_pkg::rec_t    cur_rec, cur_rec_next;
  prt_pkg::status_t wstat, wstat_next;
  logic [CW-1:0]    whit, whit_next;
  prt_pkg::rec_t    wrec, wrec_next;

  // store ports
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  prt_pkg::rec_t    mem_wdata;
  logic [AW-1:0]    mem_raddr;
  prt_pkg::rec_t    mem_rdata;

  logic             match_hit;
  logic             res_load;

  // incoming command as a record, and its position checks
  prt_pkg::rec_t    in_rec;
  logic [PW-1:0]    pos_in;
  logic [PW-1:0]    pos_in_m1;
  logic             pos_ok;
  logic             full;

  // index arithmetic; the incremented indices are one bit wider so the loop ends compare cleanly
  logic [CW:0]      idx_p1;
  logic [CW:0]      idx_p2;
  logic [CW-1:0]    idx_m1;
  logic [PW-1:0]    cur_pos_m1;

  logic [PW-1:0]    hit_ext;
  logic [PW-1:0]    count_ext;

  assign in_rec.code  = cmd.item_code;
  assign in_rec.name  = cmd.item_name;
  assign in_rec.price = cmd.unit_price;
  assign in_rec.stock = cmd.stock_level;

  assign pos_in     = PW'(cmd.position);
  assign pos_in_m1  = pos_in - PW'(1);
  assign pos_ok     = (pos_in != '0) && (pos_in <= PW'(count));
  assign full       = (count == CW'(TABLE_SLOTS));

  assign idx_p1     = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2     = {1'b0, idx} + (CW+1)'(2);
  assign idx_m1     = idx - CW'(1);
  assign cur_pos_m1 = cur_pos - PW'(1);

  assign cmd.ready  = (state == prt_pkg::S_IDLE);

  prt_store #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // one comparator serves every slot of a search
  prt_match u_match (
    .kind (cur_kind),
    .key  (cur_rec),
    .rec  (mem_rdata),
    .hit  (match_hit)
  );

  // sequencer: next state, working registers and store control
  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    cur_kind_next = cur_kind;
    cur_pos_next  = cur_pos;
    cur_rec_next  = cur_rec;
    wstat_next    = wstat;
    whit_next     = whit;
    wrec_next     = wrec;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = cur_rec;
    mem_raddr     = '0;
    res_load      = 1'b0;

    case (state)
      prt_pkg::S_IDLE: begin
        if (cmd.valid) begin
          cur_kind_next = prt_pkg::kind_t'(cmd.kind);
          cur_pos_next  = pos_in;
          cur_rec_next  = in_rec;
          wstat_next    = prt_pkg::ST_OK;
          whit_next     = '0;
          wrec_next     = '0;
          state_next    = prt_pkg::S_RESP;
          case (prt_pkg::kind_t'(cmd.kind))
            prt_pkg::KIND_CLEAR: begin
              count_next = '0;
            end
            prt_pkg::KIND_APPEND: begin
              if (full) begin
                wstat_next = prt_pkg::ST_FULL;
              end else begin
                // tail slot is written in the accepting cycle
                mem_we     = 1'b1;
                mem_waddr  = count[AW-1:0];
                mem_wdata  = in_rec;
                count_next = count + CW'(1);
                whit_next  = count + CW'(1);
              end
            end
            prt_pkg::KIND_INSERT: begin
              if (!pos_ok) begin
                wstat_next = prt_pkg::ST_BADPOS;
              end else if (full) begin
                wstat_next = prt_pkg::ST_FULL;
              end else begin
                // shift from the tail down to the insert slot
                idx_next   = count;
                state_next = prt_pkg::S_SH_RD;
              end
            end
            prt_pkg::KIND_DELETE: begin
              if (!pos_ok) begin
                wstat_next = prt_pkg::ST_BADPOS;
              end else begin
                // fetch the victim for the report
                mem_raddr  = pos_in_m1[AW-1:0];
                idx_next   = CW'(pos_in_m1);
                state_next = prt_pkg::S_DEL_CAP;
              end
            end
            prt_pkg::KIND_FIND_NAME,
            prt_pkg::KIND_FIND_PRICE,
            prt_pkg::KIND_FIND_STOCK: begin
              idx_next = '0;
              if (count == '0) begin
                wstat_next = prt_pkg::ST_NOTFOUND;
              end else begin
                state_next = prt_pkg::S_SC_RD;
              end
            end
            default: begin
              // unknown kind: plain ok with unchanged count
            end
          endcase
        end
      end

      // insert: copy slot idx-1 up into slot idx
      prt_pkg::S_SH_RD: begin
        mem_raddr  = idx_m1[AW-1:0];
        state_next = prt_pkg::S_SH_WR;
      end
      prt_pkg::S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
        idx_next  = idx_m1;
        if (PW'(idx) == cur_pos) begin
          state_next = prt_pkg::S_INS_PUT;
        end else begin
          state_next = prt_pkg::S_SH_RD;
        end
      end
      prt_pkg::S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = cur_pos_m1[AW-1:0];
        mem_wdata  = cur_rec;
        count_next = count + CW'(1);
        whit_next  = CW'(cur_pos);
        state_next = prt_pkg::S_RESP;
      end

      // delete: keep the victim, then copy slot idx+1 down into slot idx
      prt_pkg::S_DEL_CAP: begin
        wrec_next = mem_rdata;
        if (idx_p1 < {1'b0, count}) begin
          state_next = prt_pkg::S_DN_RD;
        end else begin
          state_next = prt_pkg::S_DEL_END;
        end
      end
      prt_pkg::S_DN_RD: begin
        mem_raddr  = idx_p1[AW-1:0];
        state_next = prt_pkg::S_DN_WR;
      end
      prt_pkg::S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
        idx_next  = idx_p1[CW-1:0];
        if (idx_p2 < {1'b0, count}) begin
          state_next = prt_pkg::S_DN_RD;
        end else begin
          state_next = prt_pkg::S_DEL_END;
        end
      end
      prt_pkg::S_DEL_END: begin
        count_next = count - CW'(1);
        whit_next  = CW'(cur_pos);
        state_next = prt_pkg::S_RESP;
      end

      // search: read a slot, compare it in the next cycle
      prt_pkg::S_SC_RD: begin
        mem_raddr  = idx[AW-1:0];
        state_next = prt_pkg::S_SC_CHK;
      end
      prt_pkg::S_SC_CHK: begin
        if (match_hit) begin
          wstat_next = prt_pkg::ST_OK;
          whit_next  = idx_p1[CW-1:0];
          wrec_next  = mem_rdata;
          state_next = prt_pkg::S_RESP;
        end else begin
          idx_next = idx_p1[CW-1:0];
          if (idx_p1 == {1'b0, count}) begin
            wstat_next = prt_pkg::ST_NOTFOUND;
            state_next = prt_pkg::S_RESP;
          end else begin
            state_next = prt_pkg::S_SC_RD;
          end
        end
      end

      // hand the result to the output register once it is free
      prt_pkg::S_RESP: begin
        if (!res.valid || res.ready) begin
          res_load   = 1'b1;
          state_next = prt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = prt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cur_kind <= cur_kind_next;
    cur_pos  <= cur_pos_next;
    cur_rec  <= cur_rec_next;
    wstat    <= wstat_next;
    whit     <= whit_next;
    wrec     <= wrec_next;
  end

  // narrow position and count to the 7-bit result fields
  assign hit_ext   = PW'(whit);
  assign count_ext = PW'(count);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.status       <= wstat;
      res.hit_position <= hit_ext[prt_pkg::POS_W-1:0];
      res.out_code     <= wrec.code;
      res.out_name     <= wrec.name;
      res.out_price    <= wrec.price;
      res.out_stock    <= wrec.stock;
      res.entry_total  <= count_ext[prt_pkg::POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/core/prt_store.sv
// ----------------------------------------------------------------------------
// prt_store - record store
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module prt_store #(
  parameter int TABLE_SLOTS = prt_pkg::TABLE_SLOTS_DEF,
  localparam int AW = $clog2(TABLE_SLOTS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire prt_pkg::rec_t wdata,
  input  wire logic [AW-1:0] raddr,
  output prt_pkg::rec_t      rdata
);

  prt_pkg::rec_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/prt_match.sv
// ----------------------------------------------------------------------------
// prt_match - search comparator
// compares the key field chosen by the search kind against one record
// ----------------------------------------------------------------------------
`default_nettype none

module prt_match (
  input  wire prt_pkg::kind_t kind,
  input  wire prt_pkg::rec_t  key,
  input  wire prt_pkg::rec_t  rec,
  output logic                hit
);

  always_comb begin
    case (kind)
      prt_pkg::KIND_FIND_NAME:  hit = (rec.name == key.name);
      prt_pkg::KIND_FIND_PRICE: hit = (rec.price == key.price);
      prt_pkg::KIND_FIND_STOCK: hit = (rec.stock == key.stock);
      default:                  hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire
